/* hdl/tpcs_pkg.sv */
// ----------------------------------------------------------------------------
// tpcs_pkg: shared types and constants of the three-phase current sense core
// Field widths, register indexes and the controller-to-datapath command and
// status structures.
// ----------------------------------------------------------------------------
package tpcs_pkg;

  localparam int GAIN_W     = 16;
  localparam int ALPHA_W    = 16;
  localparam int LIMIT_W    = 20;
  localparam int CNT_W      = 16;
  localparam int CAL_SUM_W  = 28;
  localparam int PH_W       = 21;
  localparam int BUS_W      = 23;
  localparam int FILT_W     = 32;
  localparam int DIFF_W     = 33;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = DIFF_W + MUL_B_W;
  localparam int DIVISOR_W  = CNT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int PH_MAX = 1048575;
  localparam int PH_MIN = -1048576;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 20'd10000;
  localparam logic [CNT_W-1:0]   COUNT_RST = 16'd200;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd3;

  typedef struct packed {
    logic       capture_in;
    logic       ph_mul;
    logic       ph_store;
    logic       flt_mul;
    logic       flt_store;
    logic       oc_update;
    logic       cal_step;
    logic       div_start;
    logic       div_store;
    logic       cal_finish;
    logic       load_out;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic cal_complete;
    logic div_done;
  } status_t;

  // Filter state (signed Q.8) to integer mA, truncated toward zero.
  function automatic logic signed [FILT_W-9:0] filt_to_ma(logic signed [FILT_W-1:0] y);
    logic signed [FILT_W-1:0] t;
    t = y + (y[FILT_W-1] ? FILT_W'(255) : FILT_W'(0));
    return t[FILT_W-1:8];
  endfunction

  function automatic logic [FILT_W-1:0] filt_abs(logic signed [FILT_W-1:0] y);
    return y[FILT_W-1] ? (~y + FILT_W'(1)) : y;
  endfunction

endpackage

/* hdl/tpcs_div.sv */
// ----------------------------------------------------------------------------
// tpcs_div: restoring divider for calibration averaging
// Divides a calibration sum by the sample count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tpcs_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [tpcs_pkg::CAL_SUM_W-1:0]       dividend_i,
  input  logic [tpcs_pkg::DIVISOR_W-1:0]       divisor_i,
  output logic                                 done_o,
  output logic [tpcs_pkg::CAL_SUM_W-1:0]       quotient_o
);

  localparam int QW   = tpcs_pkg::CAL_SUM_W;
  localparam int RW   = tpcs_pkg::DIVISOR_W + 1;
  localparam int CW   = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [tpcs_pkg::DIVISOR_W-1:0] dvs_q, dvs_d;

  logic [RW-1:0] rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q[RW-2:0], quo_q[QW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/tpcs_dp.sv */
// ----------------------------------------------------------------------------
// tpcs_dp: current sense datapath
// Configuration registers, offsets, calibration sums, the shared multiplier,
// the four low-pass filters, the overcurrent compare and the result register.
// ----------------------------------------------------------------------------
module tpcs_dp #(
  parameter int ADC_BITS    = 12,
  parameter int ZERO_OFFSET = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tpcs_pkg::cmd_t                         cmd_i,
  output tpcs_pkg::status_t                      status_o,
  input  logic                                   cfg_valid_i,
  input  logic [tpcs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tpcs_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   opcode_i,
  input  logic [ADC_BITS-1:0]                    phase_u_raw_i,
  input  logic [ADC_BITS-1:0]                    phase_v_raw_i,
  input  logic [ADC_BITS-1:0]                    phase_w_raw_i,
  output logic signed [tpcs_pkg::PH_W-1:0]       u_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       v_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       w_ma_o,
  output logic signed [tpcs_pkg::BUS_W-1:0]      bus_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       u_filtered_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       v_filtered_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       w_filtered_ma_o,
  output logic signed [tpcs_pkg::BUS_W-1:0]      bus_filtered_ma_o,
  output logic                                   overcurrent_o,
  output logic                                   calibrated_o
);

  localparam int PH_W   = tpcs_pkg::PH_W;
  localparam int BUS_W  = tpcs_pkg::BUS_W;
  localparam int FILT_W = tpcs_pkg::FILT_W;
  localparam int DIFF_W = tpcs_pkg::DIFF_W;
  localparam int PROD_W = tpcs_pkg::PROD_W;
  localparam int SUM_W  = tpcs_pkg::CAL_SUM_W;
  localparam int CNT_W  = tpcs_pkg::CNT_W;
  localparam logic [ADC_BITS-1:0] OFFSET_RST = ADC_BITS'(ZERO_OFFSET);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(tpcs_pkg::PH_MAX);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(tpcs_pkg::PH_MIN);

  // Configuration registers.
  logic [tpcs_pkg::GAIN_W-1:0]  gain_q;
  logic [tpcs_pkg::ALPHA_W-1:0] alpha_q;
  logic [tpcs_pkg::LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]             count_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= tpcs_pkg::GAIN_RST;
      alpha_q     <= tpcs_pkg::ALPHA_RST;
      limit_q     <= tpcs_pkg::LIMIT_RST;
      count_cfg_q <= tpcs_pkg::COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpcs_pkg::REG_GAIN:  gain_q      <= cfg_data_i[tpcs_pkg::GAIN_W-1:0];
        tpcs_pkg::REG_ALPHA: alpha_q     <= cfg_data_i[tpcs_pkg::ALPHA_W-1:0];
        tpcs_pkg::REG_LIMIT: limit_q     <= cfg_data_i[tpcs_pkg::LIMIT_W-1:0];
        tpcs_pkg::REG_COUNT: count_cfg_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic                opcode_q;
  logic [ADC_BITS-1:0] raw_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) begin
      opcode_q <= opcode_i;
      raw_q[0] <= phase_u_raw_i;
      raw_q[1] <= phase_v_raw_i;
      raw_q[2] <= phase_w_raw_i;
    end
  end

  // State registers.
  logic [ADC_BITS-1:0]        offset_q [3];
  logic [SUM_W-1:0]           sum_q [3];
  logic [CNT_W-1:0]           cal_count_q;
  logic                       cal_done_q;
  logic signed [FILT_W-1:0]   filt_q [4];
  logic                       oc_q;
  logic signed [PH_W-1:0]     ph_q [3];
  logic signed [PROD_W-1:0]   mult_q;
  logic [tpcs_pkg::DIVISOR_W-1:0] div_n_q;

  // Shared multiplier operands.
  logic signed [ADC_BITS:0]    ph_diff;
  logic signed [BUS_W-1:0]     bus_sum;
  logic signed [BUS_W-1:0]     x_sel;
  logic signed [DIFF_W-1:0]    flt_diff;
  logic signed [DIFF_W-1:0]    mul_a;
  logic signed [tpcs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]    rnd;
  logic signed [PROD_W-1:0]    scaled;
  logic signed [PROD_W-1:0]    clamped;
  logic [CNT_W-1:0]            count_next;
  logic [FILT_W-1:0]           lim_q8;
  logic                        oc_next;
  logic                        div_done;
  logic [SUM_W-1:0]            quotient;

  always_comb begin
    ph_diff = $signed({1'b0, raw_q[cmd_i.idx]}) - $signed({1'b0, offset_q[cmd_i.idx]});
    bus_sum = BUS_W'(ph_q[0]) + BUS_W'(ph_q[1]) + BUS_W'(ph_q[2]);
    unique case (cmd_i.idx)
      2'd0:    x_sel = BUS_W'(ph_q[0]);
      2'd1:    x_sel = BUS_W'(ph_q[1]);
      2'd2:    x_sel = BUS_W'(ph_q[2]);
      default: x_sel = bus_sum;
    endcase
    flt_diff = (DIFF_W'(x_sel) <<< 8) - DIFF_W'(filt_q[cmd_i.idx]);
    if (cmd_i.ph_mul) begin
      mul_a = DIFF_W'(ph_diff);
      mul_b = $signed({1'b0, gain_q});
    end else begin
      mul_a = flt_diff;
      mul_b = $signed({1'b0, alpha_q});
    end
    // Scale by 1/256 with truncation toward zero, then saturate.
    rnd     = mult_q + (mult_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    scaled  = rnd >>> 8;
    clamped = scaled;
    if (scaled > SAT_HI) begin
      clamped = SAT_HI;
    end else if (scaled < SAT_LO) begin
      clamped = SAT_LO;
    end
    count_next = cal_count_q + CNT_W'(1);
    lim_q8     = FILT_W'({limit_q, 8'd0});
    oc_next    = (tpcs_pkg::filt_abs(filt_q[0]) > lim_q8) ||
                 (tpcs_pkg::filt_abs(filt_q[1]) > lim_q8) ||
                 (tpcs_pkg::filt_abs(filt_q[2]) > lim_q8);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ph_mul || cmd_i.flt_mul) begin
      mult_q <= mul_a * mul_b;
    end
    if (cmd_i.ph_store) begin
      ph_q[cmd_i.idx] <= clamped[PH_W-1:0];
    end
    if (cmd_i.cal_step) begin
      div_n_q <= {count_next == '0, count_next};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        offset_q[i] <= OFFSET_RST;
        sum_q[i]    <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        filt_q[i] <= '0;
      end
      cal_count_q <= '0;
      cal_done_q  <= 1'b0;
      oc_q        <= 1'b0;
    end else begin
      if (cmd_i.flt_store) begin
        filt_q[cmd_i.idx] <= filt_q[cmd_i.idx] + $signed(mult_q[FILT_W+15:16]);
      end
      if (cmd_i.oc_update) begin
        oc_q <= oc_next;
      end
      if (cmd_i.cal_step) begin
        if (count_cfg_q == '0) begin
          // A zero count discards the sample and aborts any run.
          cal_done_q  <= 1'b0;
          cal_count_q <= '0;
          for (int i = 0; i < 3; i++) begin
            sum_q[i] <= '0;
          end
        end else begin
          if (cal_count_q == '0) begin
            cal_done_q <= 1'b0;
          end
          for (int i = 0; i < 3; i++) begin
            sum_q[i] <= sum_q[i] + SUM_W'(raw_q[i]);
          end
          cal_count_q <= count_next;
        end
      end
      if (cmd_i.div_store) begin
        offset_q[cmd_i.idx] <= quotient[ADC_BITS-1:0];
      end
      if (cmd_i.cal_finish) begin
        cal_done_q  <= 1'b1;
        cal_count_q <= '0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
      end
    end
  end

  tpcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q[cmd_i.idx]),
    .divisor_i  (div_n_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.cal_complete = (count_cfg_q != '0) &&
                                 ((count_next == '0) || (count_next >= count_cfg_q));
  assign status_o.div_done     = div_done;

  // Result register.
  logic signed [FILT_W-9:0] fu, fv, fw, fb;

  assign fu = tpcs_pkg::filt_to_ma(filt_q[0]);
  assign fv = tpcs_pkg::filt_to_ma(filt_q[1]);
  assign fw = tpcs_pkg::filt_to_ma(filt_q[2]);
  assign fb = tpcs_pkg::filt_to_ma(filt_q[3]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (opcode_q) begin
        u_ma_o   <= '0;
        v_ma_o   <= '0;
        w_ma_o   <= '0;
        bus_ma_o <= '0;
      end else begin
        u_ma_o   <= ph_q[0];
        v_ma_o   <= ph_q[1];
        w_ma_o   <= ph_q[2];
        bus_ma_o <= bus_sum;
      end
      u_filtered_ma_o   <= fu[PH_W-1:0];
      v_filtered_ma_o   <= fv[PH_W-1:0];
      w_filtered_ma_o   <= fw[PH_W-1:0];
      bus_filtered_ma_o <= fb[BUS_W-1:0];
      overcurrent_o     <= oc_q;
      calibrated_o      <= cal_done_q;
    end
  end

endmodule

/* hdl/tpcs_ctrl.sv */
// ----------------------------------------------------------------------------
// tpcs_ctrl: current sense sequencer
// Walks the datapath through the measure or calibration steps of one item and
// owns the input and result handshakes.
// ----------------------------------------------------------------------------
module tpcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpcs_pkg::cmd_t      cmd_o,
  input  tpcs_pkg::status_t   status_i
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PMUL   = 4'd1;
  localparam logic [3:0] ST_PSTORE = 4'd2;
  localparam logic [3:0] ST_FMUL   = 4'd3;
  localparam logic [3:0] ST_FSTORE = 4'd4;
  localparam logic [3:0] ST_OCMP   = 4'd5;
  localparam logic [3:0] ST_CAL    = 4'd6;
  localparam logic [3:0] ST_DSTART = 4'd7;
  localparam logic [3:0] ST_DWAIT  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture_in = 1'b1;
          idx_d   = '0;
          state_d = opcode_i ? ST_CAL : ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd_o.ph_mul = 1'b1;
        state_d = ST_PSTORE;
      end
      ST_PSTORE: begin
        cmd_o.ph_store = 1'b1;
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_FMUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_PMUL;
        end
      end
      ST_FMUL: begin
        cmd_o.flt_mul = 1'b1;
        state_d = ST_FSTORE;
      end
      ST_FSTORE: begin
        cmd_o.flt_store = 1'b1;
        if (idx_q == 2'd3) begin
          state_d = ST_OCMP;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_FMUL;
        end
      end
      ST_OCMP: begin
        cmd_o.oc_update = 1'b1;
        state_d = ST_DONE;
      end
      ST_CAL: begin
        cmd_o.cal_step = 1'b1;
        idx_d   = '0;
        state_d = status_i.cal_complete ? ST_DSTART : ST_DONE;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (idx_q == 2'd2) begin
            cmd_o.cal_finish = 1'b1;
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = ST_DSTART;
          end
        end
      end
      ST_DONE: begin
        // The result register frees up in the same cycle it is taken.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/three_phase_current_sense_core.sv */
// ----------------------------------------------------------------------------
// three_phase_current_sense_core: three-phase current sense with calibration
// Offset removal, gain scaling, bus sum, four low-pass filters, overcurrent
// detection and averaged offset calibration.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  opcode, phase U/V/W raw samples
//   out      output     out_valid_o/out_ready_i  phase, bus, filtered currents, flags
//   cfg      input      cfg_valid_i/cfg_ready_o  register index, write data
//
// A measure item runs three scaling and four filter steps, each a multiply and
// a store step on the one shared multiplier, then the overcurrent compare and
// the result load. A calibration item runs the calibration step and the result
// load; the item that ends a run adds three 28-bit divisions on the shared
// restoring divider before the load. The next item is accepted in the cycle
// after the result load; a result not yet taken holds the following one in its
// last step. Reset is asynchronous and no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_phase_current_sense_core #(
  parameter int ADC_BITS    = 12,
  parameter int ZERO_OFFSET = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   opcode_i,
  input  logic [ADC_BITS-1:0]                    phase_u_raw_i,
  input  logic [ADC_BITS-1:0]                    phase_v_raw_i,
  input  logic [ADC_BITS-1:0]                    phase_w_raw_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [tpcs_pkg::PH_W-1:0]       u_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       v_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       w_ma_o,
  output logic signed [tpcs_pkg::BUS_W-1:0]      bus_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       u_filtered_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       v_filtered_ma_o,
  output logic signed [tpcs_pkg::PH_W-1:0]       w_filtered_ma_o,
  output logic signed [tpcs_pkg::BUS_W-1:0]      bus_filtered_ma_o,
  output logic                                   overcurrent_o,
  output logic                                   calibrated_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tpcs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tpcs_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  tpcs_pkg::cmd_t    cmd;
  tpcs_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tpcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tpcs_dp #(
    .ADC_BITS    (ADC_BITS),
    .ZERO_OFFSET (ZERO_OFFSET)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .phase_u_raw_i     (phase_u_raw_i),
    .phase_v_raw_i     (phase_v_raw_i),
    .phase_w_raw_i     (phase_w_raw_i),
    .u_ma_o            (u_ma_o),
    .v_ma_o            (v_ma_o),
    .w_ma_o            (w_ma_o),
    .bus_ma_o          (bus_ma_o),
    .u_filtered_ma_o   (u_filtered_ma_o),
    .v_filtered_ma_o   (v_filtered_ma_o),
    .w_filtered_ma_o   (w_filtered_ma_o),
    .bus_filtered_ma_o (bus_filtered_ma_o),
    .overcurrent_o     (overcurrent_o),
    .calibrated_o      (calibrated_o)
  );

endmodule
